/* rtl/core/charge_drive_relay_sequencer_top_macros.svh */
// assertion macros for the charge/drive relay sequencer
`ifndef CHARGE_DRIVE_RELAY_SEQUENCER_TOP_MACROS_SVH
`define CHARGE_DRIVE_RELAY_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define CDRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, quiet during reset
`define CDRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/cdrs_pkg.sv */
// types, constants and sequence table of the charge/drive relay sequencer
package cdrs_pkg;

  localparam int WAIT_BITS  = 16;
  localparam int CFG_W      = 16;
  localparam int NUM_REGS   = 4;
  localparam int REG_W      = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int PIN_W      = 9;
  localparam int STEP_W     = 5;
  localparam int PROG_LEN   = 29;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USED_W = PIN_W + 2;
  localparam int CMP_W      = (WAIT_BITS > CFG_W) ? WAIT_BITS : CFG_W;

  localparam logic [CMP_W-1:0] WAIT_CAP = CMP_W'((64'd1 << WAIT_BITS) - 64'd1);

  typedef logic [STEP_W-1:0]    step_t;
  typedef logic [WAIT_BITS-1:0] count_t;
  typedef logic [PIN_W-1:0]     pins_t;
  typedef logic [CFG_W-1:0]     cfg_word_t;

  typedef enum logic [1:0] {K_WRITE, K_WAIT, K_SAMPLE} kind_e;
  typedef enum logic [REG_W-1:0] {REG_SHORT, REG_HALF, REG_LONG, REG_LOOP} reg_e;

  localparam pins_t P_MAIN = 9'h001;
  localparam pins_t P_ACIN = 9'h002;
  localparam pins_t P_SBAT = 9'h004;
  localparam pins_t P_ELOW = 9'h008;
  localparam pins_t P_EHI  = 9'h010;
  localparam pins_t P_EYS  = 9'h020;
  localparam pins_t P_SMPS = 9'h040;
  localparam pins_t P_BMS  = 9'h080;
  localparam pins_t P_TEL  = 9'h100;
  localparam pins_t P_NONE = 9'h000;

  localparam step_t STEP_FIRST    = 5'd0;
  localparam step_t STEP_SAMPLE   = 5'd3;
  localparam step_t STEP_LOOPWAIT = 5'd4;
  localparam step_t STEP_CHARGE   = 5'd5;
  localparam step_t STEP_DRIVE    = 5'd16;
  localparam step_t STEP_LIMIT    = STEP_W'(PROG_LEN);

  localparam cfg_word_t SHORT_RST = 16'd20;
  localparam cfg_word_t HALF_RST  = 16'd500;
  localparam cfg_word_t LONG_RST  = 16'd1000;
  localparam cfg_word_t LOOP_RST  = 16'd50;

  // one sequence op; last is the final step of the straight run it belongs to
  typedef struct packed {
    kind_e kind;
    pins_t set;
    pins_t clr;
    reg_e  rsel;
    step_t nxt;
    step_t last;
  } op_t;

  typedef struct packed {
    cfg_word_t short_wait;
    cfg_word_t half_wait;
    cfg_word_t long_wait;
    cfg_word_t loop_wait;
  } cfg_t;

  typedef struct packed {
    step_t  step;
    count_t count;
    logic   last_ac;
    pins_t  pins;
    logic   mode;
  } state_t;

  localparam op_t PROG [PROG_LEN] = '{
    // power-up
    '{K_WRITE,  P_BMS | P_ELOW | P_TEL | P_EYS | P_SMPS, P_MAIN | P_ACIN | P_SBAT,
      REG_SHORT, 5'd1, 5'd2},
    '{K_WAIT,   P_NONE, P_NONE, REG_LONG,  5'd2,  5'd2},
    '{K_WRITE,  P_EHI,  P_NONE, REG_SHORT, 5'd3,  5'd2},
    // loop
    '{K_SAMPLE, P_NONE, P_NONE, REG_SHORT, 5'd4,  5'd3},
    '{K_WAIT,   P_NONE, P_NONE, REG_LOOP,  5'd3,  5'd4},
    // into charge mode
    '{K_WRITE,  P_NONE, P_EHI,  REG_SHORT, 5'd6,  5'd15},
    '{K_WAIT,   P_NONE, P_NONE, REG_HALF,  5'd7,  5'd15},
    '{K_WRITE,  P_NONE, P_EYS,  REG_SHORT, 5'd8,  5'd15},
    '{K_WAIT,   P_NONE, P_NONE, REG_HALF,  5'd9,  5'd15},
    '{K_WRITE,  P_NONE, P_ELOW, REG_SHORT, 5'd10, 5'd15},
    '{K_WAIT,   P_NONE, P_NONE, REG_LONG,  5'd11, 5'd15},
    '{K_WRITE,  P_SBAT, P_NONE, REG_SHORT, 5'd12, 5'd15},
    '{K_WAIT,   P_NONE, P_NONE, REG_LONG,  5'd13, 5'd15},
    '{K_WRITE,  P_ACIN, P_NONE, REG_SHORT, 5'd14, 5'd15},
    '{K_WAIT,   P_NONE, P_NONE, REG_LONG,  5'd15, 5'd15},
    '{K_WRITE,  P_NONE, P_SMPS, REG_SHORT, 5'd4,  5'd15},
    // into drive mode
    '{K_WRITE,  P_NONE, P_SBAT, REG_SHORT, 5'd17, 5'd28},
    '{K_WAIT,   P_NONE, P_NONE, REG_SHORT, 5'd18, 5'd28},
    '{K_WRITE,  P_NONE, P_ACIN, REG_SHORT, 5'd19, 5'd28},
    '{K_WAIT,   P_NONE, P_NONE, REG_LONG,  5'd20, 5'd28},
    '{K_WRITE,  P_SMPS, P_NONE, REG_SHORT, 5'd21, 5'd28},
    '{K_WAIT,   P_NONE, P_NONE, REG_LONG,  5'd22, 5'd28},
    '{K_WRITE,  P_ELOW, P_NONE, REG_SHORT, 5'd23, 5'd28},
    '{K_WAIT,   P_NONE, P_NONE, REG_LONG,  5'd24, 5'd28},
    '{K_WRITE,  P_EYS,  P_NONE, REG_SHORT, 5'd25, 5'd28},
    '{K_WAIT,   P_NONE, P_NONE, REG_LONG,  5'd26, 5'd28},
    '{K_WRITE,  P_EHI,  P_NONE, REG_SHORT, 5'd27, 5'd28},
    '{K_WAIT,   P_NONE, P_NONE, REG_SHORT, 5'd28, 5'd28},
    '{K_WRITE,  P_NONE, P_MAIN, REG_SHORT, 5'd4,  5'd28}
  };

  // register value clipped to the widest count the wait counter holds
  function automatic count_t wait_target(cfg_t cfg, reg_e rsel);
    cfg_word_t        raw;
    logic [CMP_W-1:0] wide;
    unique case (rsel)
      REG_SHORT: raw = cfg.short_wait;
      REG_HALF:  raw = cfg.half_wait;
      REG_LONG:  raw = cfg.long_wait;
      REG_LOOP:  raw = cfg.loop_wait;
      default:   raw = cfg.short_wait;
    endcase
    wide = CMP_W'(raw);
    if (wide > WAIT_CAP) wide = WAIT_CAP;
    return WAIT_BITS'(wide);
  endfunction

endpackage

/* rtl/core/cdrs_step.sv */
// one tick of the sequencer: resting step, sample and following run in one pass
module cdrs_step (
  input  cdrs_pkg::state_t st_i,
  input  cdrs_pkg::cfg_t   cfg_i,
  input  logic             ac_i,
  output cdrs_pkg::state_t st_o
);
  import cdrs_pkg::*;

  typedef struct packed {
    logic  blocked;
    step_t stop;
    step_t exit_step;
    pins_t pins;
  } walk_t;

  // runs the straight run that holds pos until a wait that does not expire
  function automatic walk_t walk(step_t pos, pins_t pins, logic first_pass,
                                 logic [NUM_REGS-1:0] zero);
    walk_t w;
    logic  run;
    logic  pass;
    step_t seg_last;
    seg_last    = PROG[pos].last;
    w.blocked   = 1'b0;
    w.stop      = pos;
    w.exit_step = PROG[seg_last].nxt;
    w.pins      = pins;
    run         = 1'b1;
    for (int i = 0; i < PROG_LEN; i++) begin
      if (run && STEP_W'(i) >= pos && STEP_W'(i) <= seg_last) begin
        pass = (STEP_W'(i) == pos) ? first_pass : zero[PROG[i].rsel];
        if (PROG[i].kind == K_WRITE) begin
          w.pins = (w.pins | PROG[i].set) & ~PROG[i].clr;
        end else if (PROG[i].kind == K_WAIT && !pass) begin
          run       = 1'b0;
          w.blocked = 1'b1;
          w.stop    = STEP_W'(i);
        end
      end
    end
    return w;
  endfunction

  logic [NUM_REGS-1:0] zero;
  step_t               s;
  logic                cnt_ok;
  logic                reach;
  pins_t               pins_mid;
  walk_t               w1;
  walk_t               w2;

  always_comb begin
    zero[REG_SHORT] = (cfg_i.short_wait == '0);
    zero[REG_HALF]  = (cfg_i.half_wait == '0);
    zero[REG_LONG]  = (cfg_i.long_wait == '0);
    zero[REG_LOOP]  = (cfg_i.loop_wait == '0);

    // an out-of-range step falls back to the sample step
    s      = (st_i.step < STEP_LIMIT) ? st_i.step : STEP_SAMPLE;
    cnt_ok = (st_i.count >= wait_target(cfg_i, PROG[s].rsel));
    w1     = walk(s, st_i.pins, cnt_ok, zero);

    st_o     = st_i;
    reach    = 1'b0;
    pins_mid = st_i.pins;

    if (s == STEP_SAMPLE) begin
      reach = 1'b1;
    end else begin
      pins_mid  = w1.pins;
      st_o.pins = w1.pins;
      if (w1.blocked) begin
        st_o.step  = w1.stop;
        st_o.count = (w1.stop == s) ? st_i.count + WAIT_BITS'(1) : WAIT_BITS'(1);
      end else if (w1.exit_step == STEP_LOOPWAIT && !zero[REG_LOOP]) begin
        st_o.step  = STEP_LOOPWAIT;
        st_o.count = WAIT_BITS'(1);
      end else begin
        reach = 1'b1;
      end
    end

    w2 = walk(ac_i ? STEP_CHARGE : STEP_DRIVE, pins_mid, 1'b1, zero);

    if (reach) begin
      if (ac_i != st_i.last_ac && !w2.blocked) begin
        st_o.last_ac = ac_i;
        st_o.mode    = ac_i;
        st_o.pins    = w2.pins;
      end
      if (ac_i != st_i.last_ac && w2.blocked) begin
        st_o.last_ac = ac_i;
        st_o.mode    = ac_i;
        st_o.pins    = w2.pins;
        st_o.step    = w2.stop;
        st_o.count   = WAIT_BITS'(1);
      end else if (zero[REG_LOOP]) begin
        // loop wait of zero: the tick ends back at the sample step
        st_o.step  = STEP_SAMPLE;
        st_o.count = '0;
      end else begin
        st_o.step  = STEP_LOOPWAIT;
        st_o.count = WAIT_BITS'(1);
      end
    end
  end

endmodule

/* rtl/core/charge_drive_relay_sequencer_top.sv */
// top level of the charge/drive relay sequencer with stream and register ports
// Each input item is one timer tick carrying the sampled AC level; every item
// gives exactly one result item with the nine pin levels, the sequencing flag
// and the current mode. Items are taken one per clock cycle and the result
// appears in the cycle after acceptance: the whole tick (finishing the current
// wait, the AC sample and any run of writes whose waits are zero) is worked out
// by one combinational pass over the fixed sequence table, and a single output
// register holds the result, so a new item is accepted whenever that register
// is empty or is being read. Register writes are taken at any time (cfg_ready
// is always high) and should be made while the block is idle.
`include "charge_drive_relay_sequencer_top_macros.svh"

module charge_drive_relay_sequencer_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cdrs_pkg::IN_DATA_W-1:0]    in_tdata,    // [0] ac_present
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] main_relay, [1] ac_in_relay, [2] smps_battery_relay, [3] engine_low_relay,
  // [4] engine_high_relay, [5] energy_sys_enable, [6] smps_enable, [7] bms_enable,
  // [8] telemetry_enable, [9] sequencing, [10] charge_mode
  output logic [cdrs_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cdrs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cdrs_pkg::CFG_W-1:0]        cfg_data
);
  import cdrs_pkg::*;

  state_t                st_r;
  state_t                st_nxt;
  cfg_t                  cfg_r;
  logic                  out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;
  logic                  in_acc;
  logic                  seq_busy;

  cdrs_step u_step (
    .st_i  (st_r),
    .cfg_i (cfg_r),
    .ac_i  (in_tdata[0]),
    .st_o  (st_nxt)
  );

  assign in_tready = !out_vld_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign seq_busy     = (st_nxt.step != STEP_SAMPLE) && (st_nxt.step != STEP_LOOPWAIT);
  assign out_data_nxt = OUT_DATA_W'({st_nxt.mode, seq_busy, st_nxt.pins});

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.step    <= STEP_FIRST;
      st_r.count   <= '0;
      st_r.last_ac <= 1'b0;
      st_r.pins    <= '0;
      st_r.mode    <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      if (in_acc) begin
        st_r <= st_nxt;
      end
      if (in_acc) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_wait <= SHORT_RST;
      cfg_r.half_wait  <= HALF_RST;
      cfg_r.long_wait  <= LONG_RST;
      cfg_r.loop_wait  <= LOOP_RST;
    end else if (cfg_valid && cfg_ready && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
      unique case (reg_e'(cfg_index[REG_W-1:0]))
        REG_SHORT: cfg_r.short_wait <= cfg_data;
        REG_HALF:  cfg_r.half_wait  <= cfg_data;
        REG_LONG:  cfg_r.long_wait  <= cfg_data;
        REG_LOOP:  cfg_r.loop_wait  <= cfg_data;
        default:   cfg_r.short_wait <= cfg_r.short_wait;
      endcase
    end
  end

  `CDRS_ASSERT_NEXT(a_acc_gives_result, in_acc, out_vld_r, "accepted item gave no result")
  `CDRS_ASSERT_NEXT(a_state_holds, !in_acc, $stable(st_r), "state moved without an item")
  `CDRS_ASSERT_NOW(a_step_range, 1'b1, st_r.step < STEP_LIMIT, "step index out of range")
  `CDRS_ASSERT_NOW(a_sample_count, st_r.step == STEP_SAMPLE, st_r.count == '0,
                   "wait count left over at the sample step")

endmodule

/* verif/tb_top.sv */
// self-checking testbench for the charge/drive relay sequencer top level
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cdrs_pkg::*;

  localparam int          ITEM_TARGET = 1300;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int          SEQ_LEN     = 29;
  localparam logic [4:0]  ST_SAMPLE   = 5'd3;
  localparam logic [4:0]  ST_LOOPWAIT = 5'd4;
  localparam logic [4:0]  ST_CHARGE   = 5'd5;
  localparam logic [4:0]  ST_DRIVE    = 5'd16;

  typedef struct packed {
    pins_t pins;
    logic  busy;
    logic  mode;
  } relay_levels_t;

  typedef struct packed {
    kind_e      kind;
    pins_t      set;
    pins_t      clr;
    reg_e       rsel;
    logic [4:0] nxt;
  } relay_op_t;

  // directed rows: either a register write or one tick, optionally with typed levels
  typedef struct packed {
    bit          is_cfg;
    reg_e        rsel;
    logic [15:0] val;
    logic        ac;
    bit          typed;
    pins_t       pins;
    logic        busy;
    logic        mode;
  } tick_row_t;

  localparam int N_ROWS = 32;
  localparam tick_row_t DIRECTED [N_ROWS] = '{
    '{1'b0, REG_SHORT, 16'd0,     1'b0, 1'b1, 9'h1E8, 1'b1, 1'b0},
    '{1'b0, REG_SHORT, 16'd0,     1'b1, 1'b1, 9'h1E8, 1'b1, 1'b0},
    '{1'b1, REG_SHORT, 16'd0,     1'b0, 1'b0, 9'h000, 1'b0, 1'b0},
    '{1'b1, REG_HALF,  16'd0,     1'b0, 1'b0, 9'h000, 1'b0, 1'b0},
    '{1'b1, REG_LONG,  16'd0,     1'b0, 1'b0, 9'h000, 1'b0, 1'b0},
    '{1'b1, REG_LOOP,  16'd0,     1'b0, 1'b0, 9'h000, 1'b0, 1'b0},
    // ac already present at the first sample: charge entry with zero waits
    '{1'b0, REG_SHORT, 16'd0,     1'b1, 1'b1, 9'h186, 1'b0, 1'b1},
    '{1'b0, REG_SHORT, 16'd0,     1'b1, 1'b1, 9'h186, 1'b0, 1'b1},
    '{1'b0, REG_SHORT, 16'd0,     1'b0, 1'b1, 9'h1F8, 1'b0, 1'b0},
    '{1'b0, REG_SHORT, 16'd0,     1'b0, 1'b1, 9'h1F8, 1'b0, 1'b0},
    '{1'b1, REG_LOOP,  16'hFFFF,  1'b0, 1'b0, 9'h000, 1'b0, 1'b0},
    '{1'b0, REG_SHORT, 16'd0,     1'b1, 1'b1, 9'h186, 1'b0, 1'b1},
    '{1'b0, REG_SHORT, 16'd0,     1'b0, 1'b1, 9'h186, 1'b0, 1'b1},
    '{1'b0, REG_SHORT, 16'd0,     1'b0, 1'b0, 9'h000, 1'b0, 1'b0},
    // loop wait cut short while running
    '{1'b1, REG_LOOP,  16'd1,     1'b0, 1'b0, 9'h000, 1'b0, 1'b0},
    '{1'b0, REG_SHORT, 16'd0,     1'b0, 1'b0, 9'h000, 1'b0, 1'b0},
    '{1'b1, REG_SHORT, 16'hFFFF,  1'b0, 1'b0, 9'h000, 1'b0, 1'b0},
    '{1'b1, REG_HALF,  16'hFFFF,  1'b0, 1'b0, 9'h000, 1'b0, 1'b0},
    '{1'b1, REG_LONG,  16'hFFFF,  1'b0, 1'b0, 9'h000, 1'b0, 1'b0},
    '{1'b0, REG_SHORT, 16'd0,     1'b1, 1'b0, 9'h000, 1'b0, 1'b0},
    '{1'b0, REG_SHORT, 16'd0,     1'b1, 1'b0, 9'h000, 1'b0, 1'b0},
    '{1'b0, REG_SHORT, 16'd0,     1'b0, 1'b0, 9'h000, 1'b0, 1'b0},
    '{1'b1, REG_SHORT, 16'd3,     1'b0, 1'b0, 9'h000, 1'b0, 1'b0},
    '{1'b1, REG_HALF,  16'd2,     1'b0, 1'b0, 9'h000, 1'b0, 1'b0},
    '{1'b1, REG_LONG,  16'd4,     1'b0, 1'b0, 9'h000, 1'b0, 1'b0},
    '{1'b1, REG_LOOP,  16'd0,     1'b0, 1'b0, 9'h000, 1'b0, 1'b0},
    '{1'b0, REG_SHORT, 16'd0,     1'b1, 1'b0, 9'h000, 1'b0, 1'b0},
    '{1'b0, REG_SHORT, 16'd0,     1'b1, 1'b0, 9'h000, 1'b0, 1'b0},
    '{1'b0, REG_SHORT, 16'd0,     1'b0, 1'b0, 9'h000, 1'b0, 1'b0},
    '{1'b0, REG_SHORT, 16'd0,     1'b0, 1'b0, 9'h000, 1'b0, 1'b0},
    '{1'b0, REG_SHORT, 16'd0,     1'b1, 1'b0, 9'h000, 1'b0, 1'b0},
    '{1'b0, REG_SHORT, 16'd0,     1'b0, 1'b0, 9'h000, 1'b0, 1'b0}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  logic [31:0]   cyc = '0;
  int            n_fail = 0;
  int            n_results = 0;
  int            stall_left = 0;
  relay_levels_t pending_levels [$];

  // sequencer state as the testbench sees it
  logic [4:0]  cur_step;
  int unsigned wait_cnt;
  logic        last_ac;
  pins_t       pin_lv;
  logic        mode_lv;
  logic [15:0] wait_reg [NUM_REGS];

  // windows with no idling on either side
  wire calm = (cyc[8:7] == 2'b00);

  charge_drive_relay_sequencer_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic relay_op_t make_op(kind_e k, pins_t s, pins_t c, reg_e rs, logic [4:0] n);
    relay_op_t o;
    o.kind = k;
    o.set  = s;
    o.clr  = c;
    o.rsel = rs;
    o.nxt  = n;
    return o;
  endfunction

  function automatic relay_op_t op_at(logic [4:0] s);
    case (s)
      5'd0:  return make_op(K_WRITE, P_BMS | P_ELOW | P_TEL | P_EYS | P_SMPS,
                            P_MAIN | P_ACIN | P_SBAT, REG_SHORT, 5'd1);
      5'd1:  return make_op(K_WAIT,   P_NONE, P_NONE, REG_LONG,  5'd2);
      5'd2:  return make_op(K_WRITE,  P_EHI,  P_NONE, REG_SHORT, ST_SAMPLE);
      5'd3:  return make_op(K_SAMPLE, P_NONE, P_NONE, REG_SHORT, ST_LOOPWAIT);
      5'd4:  return make_op(K_WAIT,   P_NONE, P_NONE, REG_LOOP,  ST_SAMPLE);
      // charge entry
      5'd5:  return make_op(K_WRITE,  P_NONE, P_EHI,  REG_SHORT, 5'd6);
      5'd6:  return make_op(K_WAIT,   P_NONE, P_NONE, REG_HALF,  5'd7);
      5'd7:  return make_op(K_WRITE,  P_NONE, P_EYS,  REG_SHORT, 5'd8);
      5'd8:  return make_op(K_WAIT,   P_NONE, P_NONE, REG_HALF,  5'd9);
      5'd9:  return make_op(K_WRITE,  P_NONE, P_ELOW, REG_SHORT, 5'd10);
      5'd10: return make_op(K_WAIT,   P_NONE, P_NONE, REG_LONG,  5'd11);
      5'd11: return make_op(K_WRITE,  P_SBAT, P_NONE, REG_SHORT, 5'd12);
      5'd12: return make_op(K_WAIT,   P_NONE, P_NONE, REG_LONG,  5'd13);
      5'd13: return make_op(K_WRITE,  P_ACIN, P_NONE, REG_SHORT, 5'd14);
      5'd14: return make_op(K_WAIT,   P_NONE, P_NONE, REG_LONG,  5'd15);
      5'd15: return make_op(K_WRITE,  P_NONE, P_SMPS, REG_SHORT, ST_LOOPWAIT);
      // drive entry
      5'd16: return make_op(K_WRITE,  P_NONE, P_SBAT, REG_SHORT, 5'd17);
      5'd17: return make_op(K_WAIT,   P_NONE, P_NONE, REG_SHORT, 5'd18);
      5'd18: return make_op(K_WRITE,  P_NONE, P_ACIN, REG_SHORT, 5'd19);
      5'd19: return make_op(K_WAIT,   P_NONE, P_NONE, REG_LONG,  5'd20);
      5'd20: return make_op(K_WRITE,  P_SMPS, P_NONE, REG_SHORT, 5'd21);
      5'd21: return make_op(K_WAIT,   P_NONE, P_NONE, REG_LONG,  5'd22);
      5'd22: return make_op(K_WRITE,  P_ELOW, P_NONE, REG_SHORT, 5'd23);
      5'd23: return make_op(K_WAIT,   P_NONE, P_NONE, REG_LONG,  5'd24);
      5'd24: return make_op(K_WRITE,  P_EYS,  P_NONE, REG_SHORT, 5'd25);
      5'd25: return make_op(K_WAIT,   P_NONE, P_NONE, REG_LONG,  5'd26);
      5'd26: return make_op(K_WRITE,  P_EHI,  P_NONE, REG_SHORT, 5'd27);
      5'd27: return make_op(K_WAIT,   P_NONE, P_NONE, REG_SHORT, 5'd28);
      5'd28: return make_op(K_WRITE,  P_NONE, P_MAIN, REG_SHORT, ST_LOOPWAIT);
      default: return make_op(K_SAMPLE, P_NONE, P_NONE, REG_SHORT, ST_LOOPWAIT);
    endcase
  endfunction

  // one tick: run writes until a wait holds or the sample comes round a second time
  function automatic relay_levels_t advance_tick(logic ac);
    relay_op_t     o;
    relay_levels_t lv;
    bit            sampled;
    bit            done;
    int            guard;
    int unsigned   target;
    sampled = 1'b0;
    done    = 1'b0;
    for (guard = 0; guard < 4 * SEQ_LEN && !done; guard++) begin
      if (cur_step >= SEQ_LEN) begin
        cur_step = ST_SAMPLE;
        wait_cnt = 0;
      end
      o = op_at(cur_step);
      case (o.kind)
        K_WRITE: begin
          pin_lv   = (pin_lv | o.set) & ~o.clr;
          cur_step = o.nxt;
        end
        K_WAIT: begin
          // a register above the counter's largest count waits that largest count
          target = 32'(wait_reg[o.rsel]);
          if (target > 32'(WAIT_CAP)) target = 32'(WAIT_CAP);
          if (wait_cnt >= target) begin
            wait_cnt = 0;
            cur_step = o.nxt;
          end else begin
            wait_cnt++;
            done = 1'b1;
          end
        end
        default: begin
          if (sampled) begin
            done = 1'b1;
          end else begin
            sampled = 1'b1;
            if (ac != last_ac) begin
              last_ac  = ac;
              mode_lv  = ac;
              cur_step = ac ? ST_CHARGE : ST_DRIVE;
            end else begin
              cur_step = ST_LOOPWAIT;
            end
            wait_cnt = 0;
          end
        end
      endcase
    end
    lv.pins = pin_lv;
    lv.busy = (cur_step != ST_SAMPLE) && (cur_step != ST_LOOPWAIT);
    lv.mode = mode_lv;
    return lv;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_fail++;
    end
  endfunction

  task automatic send_tick(logic ac, bit typed, relay_levels_t typed_lv);
    int            r;
    int            gap;
    relay_levels_t lv;
    gap = 0;
    if (!calm) begin
      r = $urandom_range(0, 99);
      if (r >= 96)      gap = $urandom_range(15, 60);
      else if (r >= 70) gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(ac);
    do @(posedge clk); while (!in_tready);
    lv = advance_tick(ac);
    pending_levels.push_back(typed ? typed_lv : lv);
  endtask

  // stop offering items and let every pending result come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_e rsel, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(rsel);
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    wait_reg[rsel] = val;
  endtask

  // result side: checking and back-pressure
  always @(posedge clk) begin
    relay_levels_t want;
    logic          nxt_ready;
    int            r;
    nxt_ready = 1'b1;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_levels.size() == 0) begin
        $error("result item with nothing expected: %0h", out_tdata);
        n_fail++;
      end else begin
        want = pending_levels.pop_front();
        check_field("main_relay",         want.pins[0], out_tdata[0]);
        check_field("ac_in_relay",        want.pins[1], out_tdata[1]);
        check_field("smps_battery_relay", want.pins[2], out_tdata[2]);
        check_field("engine_low_relay",   want.pins[3], out_tdata[3]);
        check_field("engine_high_relay",  want.pins[4], out_tdata[4]);
        check_field("energy_sys_enable",  want.pins[5], out_tdata[5]);
        check_field("smps_enable",        want.pins[6], out_tdata[6]);
        check_field("bms_enable",         want.pins[7], out_tdata[7]);
        check_field("telemetry_enable",   want.pins[8], out_tdata[8]);
        check_field("sequencing",         want.busy,    out_tdata[9]);
        check_field("charge_mode",        want.mode,    out_tdata[10]);
        check_field("padding",            0,            out_tdata[OUT_DATA_W-1:11]);
      end
      n_results++;
      // long hold-off so the output register fills and the input stalls
      if (n_results == 300 || n_results == 900) stall_left = 400;
    end
    if (stall_left > 0) begin
      stall_left--;
      nxt_ready = 1'b0;
    end else if (!calm) begin
      r = $urandom_range(0, 99);
      if (r >= 96) begin
        stall_left = $urandom_range(10, 50);
        nxt_ready  = 1'b0;
      end else if (r >= 75) begin
        stall_left = $urandom_range(0, 2);
        nxt_ready  = 1'b0;
      end
    end
    out_tready <= nxt_ready;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    relay_levels_t typed_lv;
    int            n_items;
    int            phase_len;
    int            toggle_pct;
    int            r;
    logic          ac;
    logic [15:0]   v;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cur_step  = 5'd0;
    wait_cnt  = 0;
    last_ac   = 1'b0;
    pin_lv    = P_NONE;
    mode_lv   = 1'b0;
    wait_reg[REG_SHORT] = 16'd20;
    wait_reg[REG_HALF]  = 16'd500;
    wait_reg[REG_LONG]  = 16'd1000;
    wait_reg[REG_LOOP]  = 16'd50;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_ROWS; i++) begin
      if (DIRECTED[i].is_cfg) begin
        drain();
        write_reg(DIRECTED[i].rsel, DIRECTED[i].val);
      end else begin
        typed_lv.pins = DIRECTED[i].pins;
        typed_lv.busy = DIRECTED[i].busy;
        typed_lv.mode = DIRECTED[i].mode;
        send_tick(DIRECTED[i].ac, DIRECTED[i].typed, typed_lv);
      end
    end

    // random phases: fresh wait settings, then ac held with occasional (in some phases frequent) flips
    n_items = 0;
    ac      = 1'b0;
    while (n_items < ITEM_TARGET) begin
      drain();
      for (int k = 0; k < NUM_REGS; k++) begin
        r = $urandom_range(0, 99);
        if (r < 15)      v = 16'd0;
        else if (r < 75) v = 16'($urandom_range(1, 6));
        else if (r < 97) v = 16'($urandom_range(7, 60));
        else             v = 16'hFFFF;
        write_reg(reg_e'(k), v);
      end
      phase_len  = $urandom_range(80, 180);
      toggle_pct = ($urandom_range(0, 3) == 0) ? 45 : 4;
      for (int j = 0; j < phase_len; j++) begin
        if ($urandom_range(0, 99) < toggle_pct) ac = ~ac;
        send_tick(ac, 1'b0, typed_lv);
        n_items++;
      end
    end

    drain();
    if (n_fail == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
